// ----- rtl/ltkm_pkg.sv -----
// shared types and constants for the loser tree merge block
`timescale 1ns / 1ps
`default_nettype none

package ltkm_pkg;

  localparam int WAYS       = 16;
  localparam int NODE_DEPTH = 2 * WAYS;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int CHAMP_AW   = $clog2(WAYS);
  localparam int VALUE_W    = 31;
  localparam int LIST_W     = 4;
  localparam int N_W        = 5;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LIST_W-1:0]  list;
  } entry_t;

  typedef struct packed {
    logic                node_we;
    logic [NODE_AW-1:0]  node_waddr;
    entry_t              node_wdata;
    logic                champ_we;
    logic [CHAMP_AW-1:0] champ_waddr;
    entry_t              champ_wdata;
    logic [NODE_AW-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic push;
  } seq_stat_t;

endpackage

`default_nettype wire

// ----- rtl/loser_tree_kway_merge_top.sv -----
// loser tree merge of up to 16 descending lists
//
// input channel (in_valid/in_stall) carries mode, list_index and value:
//   load writes one list head into its leaf and gives no result,
//   build plays the full tournament and gives the winner,
//   replace puts a new head into the last winner's leaf and gives the new winner.
// output channel (out_valid/out_stall) carries winner_value, winner_list, exhausted.
// config channel (cfg_valid/cfg_ready) writes n_lists, taken while the block is idle.
// replace climbs from the winner's leaf to the root, one node read and compare per
//   level off the node memory; build reads both entries of each game (two reads)
//   and writes its loser and champion (one write); with a single list it reads that
//   list's leaf.
// the output register frees the input side as soon as a result is stored; a new
// transaction is taken while that result still waits. when the receiver stalls
// and a second result is ready, the sequencer holds it until the register frees.
// reset clears the control state, sets n_lists to 16 and the last winner to list 0;
// tree contents are undefined until loaded and built.
`timescale 1ns / 1ps
`default_nettype none

module loser_tree_kway_merge_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ltkm_pkg::MODE_W-1:0]   mode,
  input  wire logic [ltkm_pkg::LIST_W-1:0]   list_index,
  input  wire logic [ltkm_pkg::VALUE_W-1:0]  value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ltkm_pkg::VALUE_W-1:0]       winner_value,
  output logic [ltkm_pkg::LIST_W-1:0]        winner_list,
  output logic                               exhausted,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ltkm_pkg::N_W-1:0]      n_lists
);

  logic [ltkm_pkg::N_W-1:0] n;
  logic                     out_free;
  ltkm_pkg::entry_t         res;
  ltkm_pkg::seq_stat_t      stat;
  ltkm_pkg::mem_req_t       req;
  ltkm_pkg::entry_t         node_rdata;
  ltkm_pkg::entry_t         champ_rdata;

  assign cfg_ready = !stat.busy;

  // list count kept already limited to 1..WAYS
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= ltkm_pkg::N_W'(ltkm_pkg::WAYS);
    end else if (cfg_valid && cfg_ready) begin
      if (n_lists == '0) begin
        n <= ltkm_pkg::N_W'(1);
      end else if (n_lists > ltkm_pkg::N_W'(ltkm_pkg::WAYS)) begin
        n <= ltkm_pkg::N_W'(ltkm_pkg::WAYS);
      end else begin
        n <= n_lists;
      end
    end
  end

  ltkm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .n           (n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .list_index  (list_index),
    .value       (value),
    .out_free    (out_free),
    .res         (res),
    .stat        (stat),
    .req         (req),
    .node_rdata  (node_rdata),
    .champ_rdata (champ_rdata)
  );

  ltkm_store u_store (
    .clk         (clk),
    .req         (req),
    .node_rdata  (node_rdata),
    .champ_rdata (champ_rdata)
  );

  ltkm_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .push         (stat.push),
    .data         (res),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .winner_value (winner_value),
    .winner_list  (winner_list),
    .exhausted    (exhausted)
  );

  // a new result never overwrites one the receiver has not taken
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    stat.push |-> !(out_valid && out_stall))
    else $error("result pushed into a stalled output register");

  // a load finishes in its own cycle and leaves the sequencer idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == ltkm_pkg::MODE_LOAD) |=> !stat.busy)
    else $error("load left the sequencer busy");

  // a load never produces a result
  a_load_no_push: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == ltkm_pkg::MODE_LOAD) |-> !stat.push)
    else $error("load produced a result");

  // exhausted flag tracks a zero winner
  a_exhausted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (exhausted == (winner_value == '0)))
    else $error("exhausted flag disagrees with winner value");

endmodule

`default_nettype wire

// ----- rtl/ltkm_store.sv -----
// tree node memory and build-time champion memory, with registered reads
`timescale 1ns / 1ps
`default_nettype none

module ltkm_store (
  input  wire logic              clk,
  input  wire ltkm_pkg::mem_req_t req,
  output ltkm_pkg::entry_t       node_rdata,
  output ltkm_pkg::entry_t       champ_rdata
);

  ltkm_pkg::entry_t node_mem  [ltkm_pkg::NODE_DEPTH];
  ltkm_pkg::entry_t champ_mem [ltkm_pkg::WAYS];

  always_ff @(posedge clk) begin
    if (req.node_we) begin
      node_mem[req.node_waddr] <= req.node_wdata;
    end
    node_rdata <= node_mem[req.raddr];
  end

  // champions only live at internal positions, which are always below WAYS
  always_ff @(posedge clk) begin
    if (req.champ_we) begin
      champ_mem[req.champ_waddr] <= req.champ_wdata;
    end
    champ_rdata <= champ_mem[req.raddr[ltkm_pkg::CHAMP_AW-1:0]];
  end

endmodule

`default_nettype wire

// ----- rtl/ltkm_seq.sv -----
// sequencer for load, tournament build and replay over the node memory
`timescale 1ns / 1ps
`default_nettype none

module ltkm_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ltkm_pkg::N_W-1:0]      n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ltkm_pkg::MODE_W-1:0]   mode,
  input  wire logic [ltkm_pkg::LIST_W-1:0]   list_index,
  input  wire logic [ltkm_pkg::VALUE_W-1:0]  value,
  input  wire logic                          out_free,
  output ltkm_pkg::entry_t                   res,
  output ltkm_pkg::seq_stat_t                stat,
  output ltkm_pkg::mem_req_t                 req,
  input  wire ltkm_pkg::entry_t              node_rdata,
  input  wire ltkm_pkg::entry_t              champ_rdata
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_BLD_A   = 7'b0000010,
    S_BLD_B   = 7'b0000100,
    S_BLD_G   = 7'b0001000,
    S_BLD_ONE = 7'b0010000,
    S_CLIMB   = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t                          state, state_next;
  logic [ltkm_pkg::NODE_AW-1:0]    pos, pos_next;
  logic [ltkm_pkg::NODE_AW-1:0]    p, p_next;
  ltkm_pkg::entry_t                cur, cur_next;
  ltkm_pkg::entry_t                ent_a, ent_a_next;
  ltkm_pkg::entry_t                win, win_next;
  logic [ltkm_pkg::LIST_W-1:0]     last_winner, last_winner_next;

  logic [ltkm_pkg::NODE_AW-1:0]    leaf_lw;
  logic [ltkm_pkg::NODE_AW-1:0]    leaf_li;
  logic [ltkm_pkg::NODE_AW-1:0]    pos_odd;
  ltkm_pkg::entry_t                sel_a, sel_b, game_win, game_lose;
  logic                            a_wins;
  logic                            do_finish;
  ltkm_pkg::entry_t                fin_entry;

  assign leaf_lw = ltkm_pkg::NODE_AW'(n + {1'b0, last_winner});
  assign leaf_li = ltkm_pkg::NODE_AW'(n + {1'b0, list_index});
  assign pos_odd = {pos[ltkm_pkg::NODE_AW-1:1], 1'b1};

  // a position at or above n is a leaf, below n an internal champion
  assign sel_a = (pos >= n) ? node_rdata : champ_rdata;
  assign sel_b = (pos_odd >= n) ? node_rdata : champ_rdata;

  // the right-hand entry wins ties
  assign a_wins    = ent_a.value > sel_b.value;
  assign game_win  = a_wins ? ent_a : sel_b;
  assign game_lose = a_wins ? sel_b : ent_a;

  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    p_next           = p;
    cur_next         = cur;
    ent_a_next       = ent_a;
    win_next         = win;
    last_winner_next = last_winner;
    do_finish        = 1'b0;
    fin_entry        = win;
    req              = '0;
    stat.busy        = (state != S_IDLE);
    stat.push        = 1'b0;
    res              = win;

    case (state)
      S_IDLE: begin
        req.raddr = (mode == ltkm_pkg::MODE_BUILD) ? ltkm_pkg::NODE_AW'(1)
                                                   : (leaf_lw >> 1);
        if (in_valid) begin
          case (mode)
            ltkm_pkg::MODE_LOAD: begin
              if ({1'b0, list_index} < n) begin
                req.node_we    = 1'b1;
                req.node_waddr = leaf_li;
                req.node_wdata = '{value: value, list: list_index};
              end
            end
            ltkm_pkg::MODE_BUILD: begin
              if (n == ltkm_pkg::N_W'(1)) begin
                state_next = S_BLD_ONE;
              end else begin
                pos_next   = ltkm_pkg::NODE_AW'({n, 1'b0} - 6'd2);
                state_next = S_BLD_A;
              end
            end
            ltkm_pkg::MODE_REPLACE: begin
              if ({1'b0, last_winner} < n) begin
                req.node_we    = 1'b1;
                req.node_waddr = leaf_lw;
                req.node_wdata = '{value: value, list: last_winner};
                cur_next       = '{value: value, list: last_winner};
                p_next         = leaf_lw >> 1;
                if ((leaf_lw >> 1) == '0) begin
                  do_finish = 1'b1;
                  fin_entry = '{value: value, list: last_winner};
                end else begin
                  state_next = S_CLIMB;
                end
              end else begin
                // stale winner: report the current top unchanged
                do_finish = 1'b1;
                fin_entry = win;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_BLD_A: begin
        req.raddr  = pos;
        state_next = S_BLD_B;
      end
      S_BLD_B: begin
        req.raddr  = pos_odd;
        ent_a_next = sel_a;
        state_next = S_BLD_G;
      end
      S_BLD_G: begin
        req.node_we     = 1'b1;
        req.node_waddr  = pos >> 1;
        req.node_wdata  = game_lose;
        req.champ_we    = 1'b1;
        req.champ_waddr = pos[ltkm_pkg::CHAMP_AW:1];
        req.champ_wdata = game_win;
        if (pos == ltkm_pkg::NODE_AW'(2)) begin
          do_finish = 1'b1;
          fin_entry = game_win;
        end else begin
          pos_next   = pos - ltkm_pkg::NODE_AW'(2);
          state_next = S_BLD_A;
        end
      end
      S_BLD_ONE: begin
        do_finish = 1'b1;
        fin_entry = node_rdata;
      end
      S_CLIMB: begin
        req.raddr = p >> 1;
        // the stored loser takes over only when strictly larger
        if (cur.value < node_rdata.value) begin
          req.node_we    = 1'b1;
          req.node_waddr = p;
          req.node_wdata = cur;
          cur_next       = node_rdata;
        end
        if (p == ltkm_pkg::NODE_AW'(1)) begin
          do_finish = 1'b1;
          fin_entry = cur_next;
        end else begin
          p_next = p >> 1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          stat.push  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_finish) begin
      win_next         = fin_entry;
      last_winner_next = fin_entry.list;
      res              = fin_entry;
      if (out_free) begin
        stat.push  = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_winner <= '0;
    end else begin
      state       <= state_next;
      last_winner <= last_winner_next;
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    p     <= p_next;
    cur   <= cur_next;
    ent_a <= ent_a_next;
    win   <= win_next;
  end

endmodule

`default_nettype wire

// ----- rtl/ltkm_outreg.sv -----
// result register between the sequencer and the output channel
`timescale 1ns / 1ps
`default_nettype none

module ltkm_outreg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire ltkm_pkg::entry_t              data,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ltkm_pkg::VALUE_W-1:0]       winner_value,
  output logic [ltkm_pkg::LIST_W-1:0]        winner_list,
  output logic                               exhausted
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      winner_value <= data.value;
      winner_list  <= data.list;
      exhausted    <= (data.value == '0);
    end
  end

endmodule

`default_nettype wire
